/* sv/tkp_pkg.sv */
// Shared types and constants for the top-k scored pair register.
// No dependencies; imported by tkp_cell and top_k_scored_pair_register_top.
package tkp_pkg;

    localparam int          MAX_ENTRIES_DEF = 16;
    localparam int          POSE_W          = 16;
    localparam int          SCORE_W         = 32;
    localparam int          CNT_W           = 5;
    localparam int          PADDR_W         = 3;
    localparam int          PDATA_W         = 32;
    localparam logic [CNT_W-1:0] CAP_RESET  = CNT_W'(16);

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // register index
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [POSE_W-1:0]  first;
        logic [POSE_W-1:0]  second;
        logic [SCORE_W-1:0] score;
    } entry_t;

    // running result handed from cell to cell during a scan
    typedef struct packed {
        logic               found;
        logic [SCORE_W-1:0] best_score;
        logic [POSE_W-1:0]  best_first;
        logic [POSE_W-1:0]  best_second;
        logic [SCORE_W-1:0] lo_score;
    } scan_tok_t;

    typedef struct packed {
        logic valid;   // entry is held
        logic shift;   // take the right neighbor's entry
        logic load;    // take the new pair
    } cell_ctl_t;

    localparam scan_tok_t TOK_INIT = '{
        found:       1'b0,
        best_score:  '0,
        best_first:  '0,
        best_second: '0,
        lo_score:    '1
    };

endpackage

/* sv/tkp_cell.sv */
// One table slot of the top-k pair register: holds a pair and its score,
// folds its entry into the scan beat passed along the chain.
// Depends on tkp_pkg.
module tkp_cell
    import tkp_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int IDX_W = 4
) (
    input  logic              aclk,
    input  cell_ctl_t         ctl,
    input  entry_t            new_ent,
    input  entry_t            next_ent,
    input  logic [POSE_W-1:0] query_pose,
    input  scan_tok_t         tok_i,
    input  logic [IDX_W-1:0]  lo_i,
    output entry_t            ent_o,
    output scan_tok_t         tok_o,
    output logic [IDX_W-1:0]  lo_o
);

    entry_t            ent_reg, ent_next;
    scan_tok_t         tok_reg, tok_next;
    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic              hit, take_best, take_lo;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.load) begin
            ent_next = new_ent;
        end else if (ctl.shift) begin
            ent_next = next_ent;
        end
    end

    // best match: strictly greater keeps the earliest on ties
    // lowest: strictly less keeps the earliest on ties
    assign hit       = ctl.valid && (ent_reg.first == query_pose ||
                                     ent_reg.second == query_pose);
    assign take_best = hit && (!tok_i.found || ent_reg.score > tok_i.best_score);
    assign take_lo   = ctl.valid && ((IDX == 0) || ent_reg.score < tok_i.lo_score);

    always_comb begin
        tok_next = tok_i;
        lo_next  = lo_i;
        if (take_best) begin
            tok_next.found       = 1'b1;
            tok_next.best_score  = ent_reg.score;
            tok_next.best_first  = ent_reg.first;
            tok_next.best_second = ent_reg.second;
        end
        if (take_lo) begin
            tok_next.lo_score = ent_reg.score;
            lo_next           = IDX_W'(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        tok_reg <= tok_next;
        lo_reg  <= lo_next;
    end

    assign ent_o = ent_reg;
    assign tok_o = tok_reg;
    assign lo_o  = lo_reg;

endmodule

/* sv/top_k_scored_pair_register_top.sv */
// Top-k scored pair register: a chain of tkp_cell slots, control and APB port.
// Depends on tkp_pkg and tkp_cell.
//
// Keeps up to min(capacity, MAX_ENTRIES) scored pose pairs in insertion order
// (capacity 0 acts as 1). An insert beat is kept while the table has room;
// once full it is kept only if its score is strictly above the lowest held
// score, and then the earliest lowest entry is dropped, later entries close
// up and the new pair goes at the end. The highest pair ever kept is tracked
// (reset pair 0,1). A lookup beat reports whether the pose sits in any pair
// and the best such pair, earliest on ties. Each input beat gives one result
// beat. An insert into a table with room goes from accept straight to the
// apply state; a lookup or an insert into a full table first passes the scan
// state, in which the scan beat walks the cell chain one cell per cycle to
// find the best match and the lowest entry. One item is in work at a time;
// the result register lets the next beat in while a result waits for m_ready.
// Capacity register at byte address 0 (APB, 5 bits, reset 16); only paddr[2]
// is decoded, so addresses 0 to 3 all reach it and reads of 4 to 7 return 0.
module top_k_scored_pair_register_top
    import tkp_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [POSE_W-1:0]  s_new_first_pose,
    input  logic [POSE_W-1:0]  s_new_second_pose,
    input  logic [SCORE_W-1:0] s_new_score,
    input  logic [POSE_W-1:0]  s_query_pose,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_stored,
    output logic               m_found,
    output logic [POSE_W-1:0]  m_best_first_pose,
    output logic [POSE_W-1:0]  m_best_second_pose,
    output logic [POSE_W-1:0]  m_top_first_pose,
    output logic [POSE_W-1:0]  m_top_second_pose,
    output logic [CNT_W-1:0]   m_entry_count
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CMP_W  = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
    localparam int CAP_LIM = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;
    localparam logic [CNT_W-1:0] CAP_LIM_V = CNT_W'(CAP_LIM);
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    // ---------------- configuration ----------------
    logic [CNT_W-1:0] cap_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = PDATA_W'(cap_reg);
        end
    end

    // ---------------- control ----------------
    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]   eff_cap;
    logic               room;
    logic               s_fire, out_free, commit;

    // latched item
    logic               act_reg;
    entry_t             new_reg;
    logic [POSE_W-1:0]  qp_reg;

    // top pair
    logic [SCORE_W-1:0] top_score_reg;
    logic [POSE_W-1:0]  top_first_reg, top_second_reg;

    // result register
    logic               m_valid_reg;
    logic               stored_reg, found_reg;
    logic [POSE_W-1:0]  bf_reg, bs_reg;

    // chain
    entry_t             ent   [MAX_ENTRIES];
    scan_tok_t          tok   [MAX_ENTRIES];
    logic [IDX_W-1:0]   lo    [MAX_ENTRIES];
    cell_ctl_t          ctl   [MAX_ENTRIES];

    scan_tok_t          fin_tok;
    logic [IDX_W-1:0]   fin_lo;
    logic               do_append, do_evict, do_keep, top_upd;
    logic [CMP_W-1:0]   held_ext, held_m1, lo_ext;

    assign eff_cap = (cap_reg == '0) ? CNT_W'(1)
                   : ((cap_reg > CAP_LIM_V) ? CAP_LIM_V : cap_reg);
    assign room     = held_reg < eff_cap;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_APPLY) && out_free;

    assign fin_tok = tok[MAX_ENTRIES-1];
    assign fin_lo  = lo[MAX_ENTRIES-1];

    // outcome of the item once the scan has settled
    assign do_append = (act_reg == ACT_INSERT) && room;
    assign do_evict  = (act_reg == ACT_INSERT) && !room && held_reg != '0 &&
                       new_reg.score > fin_tok.lo_score;
    assign do_keep   = do_append || do_evict;
    assign top_upd   = do_keep && new_reg.score > top_score_reg;

    assign held_ext = CMP_W'(held_reg);
    assign held_m1  = held_ext - CMP_W'(1);
    assign lo_ext   = CMP_W'(fin_lo);

    // per-cell write controls
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            ctl[i].valid = CMP_W'(i) < held_ext;
            ctl[i].shift = commit && do_evict &&
                           CMP_W'(i) >= lo_ext && CMP_W'(i) < held_m1;
            ctl[i].load  = commit && ((do_append && CMP_W'(i) == held_ext) ||
                                      (do_evict && CMP_W'(i) == held_m1));
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            scan_tok_t        tin;
            logic [IDX_W-1:0] lin;
            entry_t           nxt;
            if (g == 0) begin : g_head
                assign tin = TOK_INIT;
                assign lin = '0;
            end else begin : g_link
                assign tin = tok[g-1];
                assign lin = lo[g-1];
            end
            if (g == MAX_ENTRIES - 1) begin : g_tail
                assign nxt = new_reg;
            end else begin : g_mid
                assign nxt = ent[g+1];
            end
            tkp_cell #(
                .IDX   (g),
                .IDX_W (IDX_W)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl[g]),
                .new_ent    (new_reg),
                .next_ent   (nxt),
                .query_pose (qp_reg),
                .tok_i      (tin),
                .lo_i       (lin),
                .ent_o      (ent[g]),
                .tok_o      (tok[g]),
                .lo_o       (lo[g])
            );
        end
    endgenerate

    // sequencer: idle -> (scan) -> apply
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_fire) begin
                    state_next = (s_action == ACT_INSERT && room) ? ST_APPLY : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == SCAN_LAST) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        held_next = held_reg;
        if (commit && do_append) begin
            held_next = held_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            held_reg       <= '0;
            top_score_reg  <= '0;
            top_first_reg  <= '0;
            top_second_reg <= POSE_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
            if (commit && top_upd) begin
                top_score_reg  <= new_reg.score;
                top_first_reg  <= new_reg.first;
                top_second_reg <= new_reg.second;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            act_reg       <= s_action;
            new_reg.first  <= s_new_first_pose;
            new_reg.second <= s_new_second_pose;
            new_reg.score  <= s_new_score;
            qp_reg        <= s_query_pose;
        end
        if (commit) begin
            stored_reg <= do_keep;
            if (act_reg == ACT_LOOKUP) begin
                found_reg <= fin_tok.found;
                bf_reg    <= fin_tok.best_first;
                bs_reg    <= fin_tok.best_second;
            end else begin
                found_reg <= 1'b0;
                bf_reg    <= '0;
                bs_reg    <= '0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_stored           = stored_reg;
    assign m_found            = found_reg;
    assign m_best_first_pose  = bf_reg;
    assign m_best_second_pose = bs_reg;
    assign m_top_first_pose   = top_first_reg;
    assign m_top_second_pose  = top_second_reg;
    assign m_entry_count      = held_reg;

endmodule
